// ===== src/bpld_pkg.sv =====
// ----------------------------------------------------------------------------
// bpld_pkg
// types and constants shared by the binary proof literal decoder modules
// ----------------------------------------------------------------------------
package bpld_pkg;

  localparam int NUMBER_BITS = 63;
  localparam int GROUP_BITS  = 7;
  localparam int MAX_BYTES   = (NUMBER_BITS + GROUP_BITS - 1) / GROUP_BITS;
  localparam int GRP_VEC_W   = GROUP_BITS * MAX_BYTES;
  localparam int CNT_W       = $clog2(MAX_BYTES + 1);
  localparam int LIT_W       = 63;
  localparam int BYTE_W      = 8;
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 4;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [BYTE_W-1:0] HDR_ADD = 8'h61;
  localparam logic [BYTE_W-1:0] HDR_DEL = 8'h64;

  typedef enum logic [2:0] {
    EV_START = 3'd0,
    EV_LIT   = 3'd1,
    EV_END   = 3'd2,
    EV_OK    = 3'd3,
    EV_ERR   = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_HEADER = 2'd1,
    ERR_OVFL   = 2'd2,
    ERR_TRUNC  = 2'd3
  } err_t;

  // one classified stream byte
  typedef struct packed {
    logic                  is_end;
    logic                  is_add;
    logic                  is_del;
    logic                  cont;
    logic [GROUP_BITS-1:0] grp;
  } item_t;

endpackage

// ===== src/bpld_front.sv =====
// ----------------------------------------------------------------------------
// bpld_front
// accepts stream bytes and classifies them into queue entries
// ----------------------------------------------------------------------------
module bpld_front (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bpld_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [bpld_pkg::IN_TUSER_W-1:0] in_tuser,
  input  logic                           q_full,
  output logic                           q_push,
  output bpld_pkg::item_t                q_item
);
  import bpld_pkg::*;

  logic [BYTE_W-1:0] byte_w;

  assign byte_w    = in_tdata[BYTE_W-1:0];
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_item.is_end = in_tuser[0];
    q_item.is_add = (byte_w == HDR_ADD);
    q_item.is_del = (byte_w == HDR_DEL);
    q_item.cont   = byte_w[GROUP_BITS];
    q_item.grp    = byte_w[GROUP_BITS-1:0];
  end

endmodule

// ===== src/bpld_queue.sv =====
// ----------------------------------------------------------------------------
// bpld_queue
// short register queue between the front and the back
// ----------------------------------------------------------------------------
module bpld_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bpld_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output bpld_pkg::item_t pop_item
);
  import bpld_pkg::*;

  item_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/bpld_back.sv =====
// ----------------------------------------------------------------------------
// bpld_back
// clause state, varint assembly and event output register
// ----------------------------------------------------------------------------
module bpld_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_not_empty,
  input  bpld_pkg::item_t                  q_item,
  output logic                             q_pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bpld_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [bpld_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import bpld_pkg::*;

  logic                   in_clause_r, in_clause_nxt;
  logic                   halted_r, halted_nxt;
  logic [NUMBER_BITS-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  event_t                 ev_r, ev_nxt;
  logic                   del_r, del_nxt;
  logic [LIT_W-1:0]       lit_r, lit_nxt;
  err_t                   err_r, err_nxt;

  logic                   take;
  logic                   emit;
  logic [GRP_VEC_W-1:0]   grp_vec;
  logic [NUMBER_BITS-1:0] value;
  logic [LIT_W-1:0]       mag;

  assign take  = q_not_empty && (!out_valid_r || out_tready);
  assign q_pop = take;

  // place the 7-bit group at the position of the current byte
  always_comb begin
    grp_vec = '0;
    for (int g = 0; g < MAX_BYTES; g++) begin
      if (cnt_r == CNT_W'(g)) begin
        grp_vec[g*GROUP_BITS +: GROUP_BITS] = q_item.grp;
      end
    end
  end

  assign value = acc_r | grp_vec[NUMBER_BITS-1:0];
  assign mag   = LIT_W'(value >> 1);

  always_comb begin
    in_clause_nxt = in_clause_r;
    halted_nxt    = halted_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    emit          = 1'b0;
    ev_nxt        = EV_OK;
    del_nxt       = 1'b0;
    lit_nxt       = '0;
    err_nxt       = ERR_NONE;
    if (take && !halted_r) begin
      if (!in_clause_r) begin
        emit = 1'b1;
        if (q_item.is_end) begin
          ev_nxt     = EV_OK;
          halted_nxt = 1'b1;
        end else if (q_item.is_add || q_item.is_del) begin
          ev_nxt        = EV_START;
          del_nxt       = q_item.is_del;
          in_clause_nxt = 1'b1;
          acc_nxt       = '0;
          cnt_nxt       = '0;
        end else begin
          ev_nxt     = EV_ERR;
          err_nxt    = ERR_HEADER;
          halted_nxt = 1'b1;
        end
      end else if (cnt_r >= CNT_W'(MAX_BYTES)) begin
        emit       = 1'b1;
        ev_nxt     = EV_ERR;
        err_nxt    = ERR_OVFL;
        halted_nxt = 1'b1;
      end else if (q_item.is_end) begin
        emit       = 1'b1;
        ev_nxt     = EV_ERR;
        err_nxt    = ERR_TRUNC;
        halted_nxt = 1'b1;
      end else if (q_item.cont) begin
        acc_nxt = value;
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        acc_nxt = '0;
        cnt_nxt = '0;
        emit    = 1'b1;
        if (mag == '0) begin
          // a decoded zero (value 0 or 1) closes the clause
          ev_nxt        = EV_END;
          in_clause_nxt = 1'b0;
        end else begin
          ev_nxt  = EV_LIT;
          lit_nxt = value[0] ? (LIT_W'(0) - mag) : mag;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_clause_r <= 1'b0;
      halted_r    <= 1'b0;
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      in_clause_r <= in_clause_nxt;
      halted_r    <= halted_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ev_r  <= ev_nxt;
      del_r <= del_nxt;
      lit_r <= lit_nxt;
      err_r <= err_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({err_r, lit_r});
  assign out_tuser  = {del_r, ev_r};

endmodule

// ===== src/binary_proof_literal_decoder.sv =====
// ----------------------------------------------------------------------------
// binary_proof_literal_decoder
// streaming decoder of binary clausal proofs into clause and literal events
// ----------------------------------------------------------------------------
// Takes one proof byte per cycle and keeps taking one per cycle as long as the
// result side keeps up: a byte that closes a literal or a clause goes through
// the back end's combinational shift-or and negate path. Bytes pass through a
// two-entry queue into the decode stage, and each event sits in an output
// register, so a byte is held in the queue and its event in the output
// register before out_tvalid rises. Continuation bytes give no event. After
// the stream-finished event or any error event the block swallows every
// further byte until reset.
module binary_proof_literal_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] data_byte
  input  logic [bpld_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] stream_end
  input  logic [bpld_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [62:0] literal, [64:63] error_code, [71:65] zero
  output logic [bpld_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [2:0] event_res, [3] is_delete
  output logic [bpld_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import bpld_pkg::*;

  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  q_not_empty;
  item_t push_item;
  item_t pop_item;

  bpld_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  bpld_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (pop_item)
  );

  bpld_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_item      (pop_item),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule
